[hdl/wrmon_pkg.sv]
// wrmon_pkg: constants and codes for the windowed event rate monitor
// no dependencies; imported by windowed_event_rate_monitor and tb_top
package wrmon_pkg;

    localparam int BUCKETS_DEFAULT = 64;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;

    localparam int RATE_FRAC = 16;
    localparam int TOTAL_W   = 38;

    // status codes
    localparam logic [1:0] STATUS_MISSING = 2'd0;
    localparam logic [1:0] STATUS_WARMING = 2'd1;
    localparam logic [1:0] STATUS_FRESH   = 2'd2;
    localparam logic [1:0] STATUS_STALE   = 2'd3;

    // operations
    localparam logic OP_POLL        = 1'b0;
    localparam logic OP_RESET_EPOCH = 1'b1;

    // source kinds
    localparam logic SRC_LAUNCH = 1'b0;
    localparam logic SRC_CUSTOM = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_KIND = 2'd0;
    localparam logic [1:0] CFG_INTERVAL_MS = 2'd1;
    localparam logic [1:0] CFG_BUCKET_CNT  = 2'd2;
    localparam logic [1:0] CFG_STALE_MS    = 2'd3;

endpackage

[hdl/windowed_event_rate_monitor.sv]
// windowed_event_rate_monitor: sliding window event rate meter, top level
// depends on wrmon_pkg; holds the bucket ring memory and the bit-serial divider
//
// A poll or a reset epoch is taken one transaction at a time, through states P1, P2 and
// START; a reset epoch then gives its result. A poll goes on through GAP, then LOOP and
// CLOSE for each bucket boundary it closes (at most bucket_count + 1), then LOOP and SRC.
// A poll that returns early gives its result from SRC; any other poll takes one quotient
// bit per cycle in the restoring divider that forms the rate (64 bits at BUCKETS = 64),
// then FIN. The result may further wait for m_ready. The bucket ring is read and written
// through one port, one read and one write per closed bucket; the divider shares one
// subtract and compare unit over all quotient bits; derived timing is registered.
module windowed_event_rate_monitor
    import wrmon_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [62:0] s_now_ns,
    input  logic        s_source_present,
    input  logic        s_source_seeded,
    input  logic [63:0] s_source_total,
    input  logic [62:0] s_source_last_event_ns,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_rate_value,
    output logic [TOTAL_W-1:0] m_window_total,
    output logic [63:0] m_sequence_res,
    output logic [62:0] m_mark_ns,
    output logic [62:0] m_last_source_ns
);

    localparam int HW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW    = $clog2(BUCKETS + 1);
    localparam int SUM_W = ($clog2(BUCKETS) + 32 > TOTAL_W) ? $clog2(BUCKETS) + 32 : TOTAL_W;
    localparam int QW    = SUM_W + 10;
    localparam int NW    = QW + RATE_FRAC;
    localparam int DW    = CW + 16;
    localparam int WW    = DW + 20;
    localparam int KW    = $clog2(NW + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_P1    = 4'd1;
    localparam logic [3:0] ST_P2    = 4'd2;
    localparam logic [3:0] ST_START = 4'd3;
    localparam logic [3:0] ST_GAP   = 4'd4;
    localparam logic [3:0] ST_LOOP  = 4'd5;
    localparam logic [3:0] ST_CLOSE = 4'd6;
    localparam logic [3:0] ST_SRC   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // configuration
    logic        kind_reg;
    logic [15:0] interval_reg;
    logic [6:0]  count_reg;
    logic [31:0] stale_ms_reg;

    // derived timing
    logic [35:0] bucket_ns_reg;
    logic [DW-1:0] div_d_reg;
    logic [WW-1:0] window_ns_reg;
    logic [51:0] stale_ns_reg;

    // window state
    logic [31:0] mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    logic [31:0] rd_reg;
    logic [HW-1:0] head_reg;
    logic [CW-1:0] closed_reg;
    logic [63:0] close_total_reg;
    logic [SUM_W-1:0] sum_reg;
    logic        baseline_reg;
    logic [63:0] last_total_reg;
    logic [62:0] last_tick_reg;
    logic        tick_seen_reg;
    logic [63:0] next_bnd_reg;
    logic [62:0] held_obs_reg;
    logic [63:0] held_rate_reg;
    logic [62:0] held_src_reg;

    // transaction in flight
    logic [3:0]  state_reg;
    logic        op_reg;
    logic [62:0] now_reg;
    logic        present_reg;
    logic        seeded_reg;
    logic [63:0] total_reg;
    logic [62:0] last_ev_reg;
    logic [62:0] src_reg;
    logic [1:0]  status_reg;
    logic [HW-1:0] new_head_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [KW-1:0] bit_cnt_reg;

    // result register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [63:0] m_rate_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic [63:0] m_seq_reg;
    logic [62:0] m_obs_reg;
    logic [62:0] m_src_reg;

    logic [CW-1:0] n_eff;
    logic [15:0]   interval_eff;
    logic [CW-1:0] head_inc;
    logic [HW-1:0] head_next;
    logic [63:0]   close_src;
    logic [63:0]   delta_raw;
    logic [31:0]   delta;
    logic [31:0]   old_cnt;
    logic [DW:0]   rem_sh;
    logic          rem_ge;
    logic [62:0]   src_next;
    logic          tick_next;

    always_comb begin
        if (count_reg == 7'd0) begin
            n_eff = CW'(1);
        end else if (32'(count_reg) > 32'(BUCKETS)) begin
            n_eff = CW'(BUCKETS);
        end else begin
            n_eff = CW'(count_reg);
        end
        interval_eff = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
        head_inc  = CW'(head_reg) + CW'(1);
        head_next = (head_inc >= n_eff) ? '0 : HW'(head_inc);

        // delta for one bucket close
        if (kind_reg == SRC_LAUNCH) begin
            close_src = total_reg;
        end else begin
            close_src = present_reg ? total_reg : 64'd0;
        end
        delta_raw = baseline_reg ? close_src - last_total_reg : 64'd0;
        delta     = (delta_raw[63:32] != 32'd0) ? 32'hFFFF_FFFF : delta_raw[31:0];
        old_cnt   = valid_reg[new_head_reg] ? rd_reg : 32'd0;

        // one restoring division step
        rem_sh = {rem_reg, num_reg[NW-1]};
        rem_ge = rem_sh >= {1'b0, div_d_reg};

        // custom mode tick tracking for the source step
        tick_next = tick_seen_reg || (total_reg != 64'd0);
        src_next  = (!tick_seen_reg && total_reg != 64'd0) ? now_reg : last_tick_reg;
    end

    // derived timing follows the config registers every cycle
    always_ff @(posedge aclk) begin
        bucket_ns_reg <= 36'(interval_eff * NS_PER_MS);
        div_d_reg     <= DW'(n_eff * interval_eff);
        window_ns_reg <= WW'(div_d_reg * NS_PER_MS);
        stale_ns_reg  <= 52'(stale_ms_reg * NS_PER_MS);
    end

    // ring memory, one port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOP) begin
            rd_reg <= mem[head_next];
        end
        if (state_reg == ST_CLOSE) begin
            mem[new_head_reg] <= delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg        <= SRC_LAUNCH;
            interval_reg    <= 16'd1000;
            count_reg       <= 7'd10;
            stale_ms_reg    <= 32'd5000;
            valid_reg       <= '0;
            head_reg        <= '0;
            closed_reg      <= '0;
            close_total_reg <= '0;
            sum_reg         <= '0;
            baseline_reg    <= 1'b0;
            last_total_reg  <= '0;
            last_tick_reg   <= '0;
            tick_seen_reg   <= 1'b0;
            next_bnd_reg    <= '0;
            held_obs_reg    <= '0;
            held_rate_reg   <= '0;
            held_src_reg    <= '0;
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index) inside
                    CFG_SOURCE_KIND: kind_reg <= cfg_data[0];
                    CFG_INTERVAL_MS, CFG_BUCKET_CNT: begin
                        if (cfg_index == CFG_INTERVAL_MS) begin
                            interval_reg <= cfg_data[15:0];
                        end else begin
                            count_reg <= cfg_data[6:0];
                        end
                        valid_reg    <= '0;
                        sum_reg      <= '0;
                        closed_reg   <= '0;
                        baseline_reg <= 1'b0;
                        head_reg     <= '0;
                        next_bnd_reg <= '0;
                    end
                    CFG_STALE_MS: stale_ms_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg      <= s_operation;
                        now_reg     <= s_now_ns;
                        present_reg <= s_source_present;
                        seeded_reg  <= s_source_seeded;
                        total_reg   <= s_source_total;
                        last_ev_reg <= s_source_last_event_ns;
                        state_reg   <= ST_P1;
                    end
                end
                ST_P1: state_reg <= ST_P2;
                ST_P2: state_reg <= ST_START;
                ST_START: begin
                    if (op_reg == OP_RESET_EPOCH) begin
                        valid_reg    <= '0;
                        sum_reg      <= '0;
                        closed_reg   <= '0;
                        baseline_reg <= 1'b0;
                        next_bnd_reg <= {1'b0, now_reg} + 64'(bucket_ns_reg);
                        held_obs_reg <= now_reg;
                        status_reg   <= STATUS_WARMING;
                        state_reg    <= ST_OUT;
                    end else begin
                        if (next_bnd_reg == 64'd0) begin
                            next_bnd_reg <= {1'b0, now_reg} + 64'(bucket_ns_reg);
                            held_obs_reg <= now_reg;
                        end
                        state_reg <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    // gap longer than the window: restart timing at the poll
                    if ({1'b0, now_reg} > next_bnd_reg &&
                        {1'b0, now_reg} - next_bnd_reg > 64'(window_ns_reg)) begin
                        valid_reg    <= '0;
                        sum_reg      <= '0;
                        closed_reg   <= '0;
                        baseline_reg <= 1'b0;
                        next_bnd_reg <= {1'b0, now_reg} + 64'(bucket_ns_reg);
                        held_obs_reg <= now_reg;
                    end
                    state_reg <= ST_LOOP;
                end
                ST_LOOP: begin
                    if ({1'b0, now_reg} >= next_bnd_reg) begin
                        new_head_reg <= head_next;
                        state_reg    <= ST_CLOSE;
                    end else begin
                        state_reg <= ST_SRC;
                    end
                end
                ST_CLOSE: begin
                    head_reg <= new_head_reg;
                    if (closed_reg < n_eff) begin
                        closed_reg <= closed_reg + CW'(1);
                    end
                    close_total_reg <= close_total_reg + 64'd1;
                    if (kind_reg == SRC_CUSTOM && close_src != 64'd0) begin
                        tick_seen_reg <= 1'b1;
                    end
                    last_total_reg <= close_src;
                    baseline_reg   <= 1'b1;
                    sum_reg        <= sum_reg - SUM_W'(old_cnt) + SUM_W'(delta);
                    valid_reg[new_head_reg] <= 1'b1;
                    if (delta != 32'd0) begin
                        last_tick_reg <= next_bnd_reg[62:0];
                    end
                    held_obs_reg <= next_bnd_reg[62:0];
                    next_bnd_reg <= next_bnd_reg + 64'(bucket_ns_reg);
                    state_reg    <= ST_LOOP;
                end
                ST_SRC: begin
                    num_reg     <= NW'(QW'(sum_reg * MS_PER_S)) << RATE_FRAC;
                    rem_reg     <= '0;
                    bit_cnt_reg <= KW'(NW);
                    if (kind_reg == SRC_LAUNCH) begin
                        if (!seeded_reg) begin
                            held_obs_reg <= now_reg;
                            status_reg   <= STATUS_WARMING;
                            state_reg    <= ST_OUT;
                        end else begin
                            src_reg   <= last_ev_reg;
                            state_reg <= ST_DIV;
                        end
                    end else if (!present_reg) begin
                        held_obs_reg <= now_reg;
                        status_reg   <= STATUS_MISSING;
                        state_reg    <= ST_OUT;
                    end else begin
                        tick_seen_reg <= tick_next;
                        last_tick_reg <= src_next;
                        if (!tick_next) begin
                            held_obs_reg <= now_reg;
                            status_reg   <= STATUS_WARMING;
                            state_reg    <= ST_OUT;
                        end else begin
                            src_reg   <= src_next;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // num_reg shifts out the dividend and fills with quotient bits
                    if (rem_ge) begin
                        rem_reg <= DW'(rem_sh - {1'b0, div_d_reg});
                    end else begin
                        rem_reg <= DW'(rem_sh);
                    end
                    num_reg     <= {num_reg[NW-2:0], rem_ge};
                    bit_cnt_reg <= bit_cnt_reg - KW'(1);
                    if (bit_cnt_reg == KW'(1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    held_rate_reg <= ((num_reg >> 64) != '0) ? '1 : num_reg[63:0];
                    held_src_reg  <= src_reg;
                    if (closed_reg < n_eff) begin
                        status_reg <= STATUS_WARMING;
                    end else if (now_reg > src_reg &&
                                 now_reg - src_reg > 63'(stale_ns_reg)) begin
                        status_reg <= STATUS_STALE;
                    end else begin
                        status_reg <= STATUS_FRESH;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_rate_reg   <= held_rate_reg;
                        m_total_reg  <= sum_reg[TOTAL_W-1:0];
                        m_seq_reg    <= close_total_reg;
                        m_obs_reg    <= held_obs_reg;
                        m_src_reg    <= held_src_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_rate_value     = m_rate_reg;
    assign m_window_total   = m_total_reg;
    assign m_sequence_res   = m_seq_reg;
    assign m_mark_ns        = m_obs_reg;
    assign m_last_source_ns = m_src_reg;

`ifndef SYNTHESIS
    a_head_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(head_reg) < n_eff)
        else $error("ring head beyond bucket count");

    a_closed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg <= n_eff)
        else $error("closed bucket count beyond bucket count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");
`endif

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for windowed_event_rate_monitor
// depends on wrmon_pkg and the windowed_event_rate_monitor rtl; keeps its own rate meter
// prediction and checks every result transaction field by field
module tb_top
    import wrmon_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int IDLE_PAUSE   = 300;
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [62:0] now;
        logic        present;
        logic        seeded;
        logic [63:0] total;
        logic [62:0] last_ev;
    } poll_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] rate;
        logic [37:0] wtotal;
        logic [63:0] seq;
        logic [62:0] observed;
        logic [62:0] src;
    } rate_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [62:0] s_now_ns = '0;
    logic        s_source_present = 1'b0;
    logic        s_source_seeded = 1'b0;
    logic [63:0] s_source_total = '0;
    logic [62:0] s_source_last_event_ns = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [63:0] m_rate_value;
    logic [TOTAL_W-1:0] m_window_total;
    logic [63:0] m_sequence_res;
    logic [62:0] m_mark_ns;
    logic [62:0] m_last_source_ns;

    windowed_event_rate_monitor dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow configuration and window state
    logic        sh_kind;
    logic [15:0] sh_interval;
    logic [6:0]  sh_count;
    logic [31:0] sh_stale;
    logic [31:0] ring [64];
    int          head;
    int          closed;
    logic [63:0] close_total, wsum, last_total, last_tick, next_bnd;
    logic [63:0] held_obs, held_rate, held_src;
    bit          base_ok, tick_seen;

    rate_rec_t   expected_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic [63:0] t_ns;
    logic [63:0] counter;

    function automatic int ring_len();
        int n;
        n = sh_count;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic logic [63:0] interval_ms();
        return (sh_interval != 0) ? 64'(sh_interval) : 64'd1;
    endfunction

    function automatic logic [63:0] window_rate();
        logic [63:0] q, d, ip, r;
        q = wsum * 64'd1000;
        d = 64'(ring_len()) * interval_ms();
        ip = q / d;
        r = q % d;
        if (ip >= (64'd1 << 48)) return '1;
        return (ip << 16) | ((r << 16) / d);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < 64; i++) ring[i] = '0;
        wsum = '0;
        closed = 0;
        base_ok = 0;
    endtask

    task automatic reset_shadow();
        sh_kind = SRC_LAUNCH;
        sh_interval = 16'd1000;
        sh_count = 7'd10;
        sh_stale = 32'd5000;
        clear_window();
        head = 0;
        close_total = '0;
        last_total = '0;
        last_tick = '0;
        tick_seen = 0;
        next_bnd = '0;
        held_obs = '0;
        held_rate = '0;
        held_src = '0;
    endtask

    task automatic close_bucket(input logic [63:0] bnd, input poll_t p);
        int n;
        logic [63:0] tot, delta;
        n = ring_len();
        head = (head + 1) % n;
        if (closed < n) closed++;
        close_total++;
        if (sh_kind == SRC_LAUNCH) begin
            tot = p.total;
        end else begin
            tot = p.present ? p.total : 64'd0;
            if (tot != 0) tick_seen = 1;
        end
        delta = base_ok ? tot - last_total : 64'd0;
        if (delta > 64'hFFFF_FFFF) delta = 64'hFFFF_FFFF;
        last_total = tot;
        base_ok = 1;
        wsum -= 64'(ring[head]);
        ring[head] = delta[31:0];
        wsum += delta;
        if (delta != 0) last_tick = bnd & MASK63;
        held_obs = bnd & MASK63;
    endtask

    task automatic predict_rate(input poll_t p);
        logic [63:0] now, bns, wns, sns, src;
        logic [1:0]  st;
        bit          early;
        rate_rec_t   rec;
        now = {1'b0, p.now};
        bns = interval_ms() * 64'd1000000;
        wns = 64'(ring_len()) * bns;
        sns = 64'(sh_stale) * 64'd1000000;
        early = 0;
        src = '0;
        st = STATUS_WARMING;
        if (p.op == OP_RESET_EPOCH) begin
            clear_window();
            next_bnd = now + bns;
            held_obs = now;
        end else begin
            if (next_bnd == 0) begin
                next_bnd = now + bns;
                held_obs = now;
            end
            // gap longer than the window restarts bucket timing
            if (now > next_bnd && now - next_bnd > wns) begin
                clear_window();
                next_bnd = now + bns;
                held_obs = now;
            end
            while (now >= next_bnd) begin
                close_bucket(next_bnd, p);
                next_bnd += bns;
            end
            if (sh_kind == SRC_LAUNCH) begin
                if (!p.seeded) begin
                    held_obs = now;
                    st = STATUS_WARMING;
                    early = 1;
                end else begin
                    src = {1'b0, p.last_ev};
                end
            end else if (!p.present) begin
                held_obs = now;
                st = STATUS_MISSING;
                early = 1;
            end else begin
                if (!tick_seen && p.total != 0) begin
                    tick_seen = 1;
                    last_tick = now;
                end
                if (!tick_seen) begin
                    held_obs = now;
                    st = STATUS_WARMING;
                    early = 1;
                end else begin
                    src = last_tick;
                end
            end
            if (!early) begin
                held_rate = window_rate();
                held_src = src;
                if (closed < ring_len()) st = STATUS_WARMING;
                else if (now > src && now - src > sns) st = STATUS_STALE;
                else st = STATUS_FRESH;
            end
        end
        rec = '{st, held_rate, wsum[37:0], close_total, held_obs[62:0], held_src[62:0]};
        expected_q.insert(expected_q.size(), rec);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx) inside
            CFG_SOURCE_KIND: sh_kind = val[0];
            CFG_INTERVAL_MS, CFG_BUCKET_CNT: begin
                if (idx == CFG_INTERVAL_MS) sh_interval = val[15:0];
                else sh_count = val[6:0];
                clear_window();
                head = 0;
                next_bnd = '0;
            end
            default: sh_stale = val;
        endcase
        repeat (4) @(posedge aclk);
    endtask

    // block must be idle before a register write
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
    endtask

    task automatic send_poll(input poll_t p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= p.op;
        s_now_ns <= p.now;
        s_source_present <= p.present;
        s_source_seeded <= p.seeded;
        s_source_total <= p.total;
        s_source_last_event_ns <= p.last_ev;
        do @(posedge aclk); while (!s_ready);
        predict_rate(p);
    endtask

    function automatic poll_t mk(input logic op, input logic [63:0] now, input logic pr,
                                 input logic sd, input logic [63:0] tot,
                                 input logic [63:0] lev);
        return '{op, now[62:0], pr, sd, tot, lev[62:0]};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [63:0] t0, ms;
        t0 = 64'd1_000_000_000;
        ms = 64'd1_000_000;
        write_reg(CFG_SOURCE_KIND, 32'(SRC_LAUNCH));
        write_reg(CFG_INTERVAL_MS, 32'd1);
        write_reg(CFG_BUCKET_CNT, 32'd3);
        write_reg(CFG_STALE_MS, 32'd2);
        send_poll(mk(OP_POLL, t0, 1, 0, 0, 0));                        // not seeded
        send_poll(mk(OP_POLL, t0 + ms, 1, 1, 5, t0));
        send_poll(mk(OP_POLL, t0 + 5 * ms / 2, 1, 1, 15, t0 + 2 * ms));
        send_poll(mk(OP_POLL, t0 + 3 * ms, 1, 1, 64'hFFFF_FFFF_FFFF_FFFD, t0 + 3 * ms));
        send_poll(mk(OP_POLL, t0 + 4 * ms, 1, 1, 4, t0 + 4 * ms));      // counter wrap
        send_poll(mk(OP_POLL, t0 + 5 * ms, 1, 1, 9, t0 + 5 * ms));
        send_poll(mk(OP_POLL, t0 + 6 * ms, 1, 1, 9, t0));              // stale
        send_poll(mk(OP_POLL, t0 + 6 * ms, 1, 1, 9, t0 + 9 * ms));      // source in future
        send_poll(mk(OP_POLL, t0 + 5 * ms, 1, 1, 20, t0));             // time backwards
        send_poll(mk(OP_POLL, t0 + 100 * ms, 1, 1, 30, t0));           // long gap
        send_poll(mk(OP_RESET_EPOCH, t0 + 201 * ms / 2, 0, 0, 0, 0));
        send_poll(mk(OP_POLL, t0 + 102 * ms, 1, 1, '1, MASK63));
        send_poll(mk(OP_POLL, t0 + 106 * ms, 1, 1, 40, MASK63));
        wait_idle();
        write_reg(CFG_SOURCE_KIND, 32'(SRC_CUSTOM));
        write_reg(CFG_STALE_MS, 32'd0);
        send_poll(mk(OP_POLL, t0 + 107 * ms, 0, 1, 7, 0));             // counter absent
        send_poll(mk(OP_POLL, t0 + 108 * ms, 1, 0, 0, 0));             // never ticked
        send_poll(mk(OP_POLL, t0 + 109 * ms, 1, 0, 100, 0));           // first tick
        send_poll(mk(OP_POLL, t0 + 113 * ms, 1, 0, 160, 0));
        send_poll(mk(OP_POLL, t0 + 117 * ms, 1, 0, 160, 0));
        wait_idle();
        write_reg(CFG_INTERVAL_MS, 32'hFFFF_FFFF);
        write_reg(CFG_BUCKET_CNT, 32'd127);
        write_reg(CFG_STALE_MS, 32'hFFFF_FFFF);
        send_poll(mk(OP_POLL, 64'h7FFF_F000_0000_0000, 1, 1, 1, 0));
        send_poll(mk(OP_POLL, MASK63, 1, 1, 500, 0));
        wait_idle();
        write_reg(CFG_INTERVAL_MS, 32'd0);
        write_reg(CFG_BUCKET_CNT, 32'd0);
        send_poll(mk(OP_POLL, 64'd5, 1, 1, 3, 0));
        send_poll(mk(OP_POLL, 64'd3_000_005, 1, 1, 9, 0));
        send_poll(mk(OP_POLL, 64'd4_000_005, 1, 1, 12, 64'd4_000_005));
    endtask

    task automatic random_config();
        int r;
        logic [31:0] v;
        write_reg(CFG_SOURCE_KIND, {$urandom} & ~32'd1 | 32'($urandom_range(1)));
        r = $urandom_range(99);
        if (r < 80) v = $urandom_range(1, 4);
        else if (r < 90) v = 0;
        else v = $urandom_range(0, 65535);
        write_reg(CFG_INTERVAL_MS, {$urandom} & 32'hFFFF_0000 | v);
        r = $urandom_range(99);
        if (r < 70) v = $urandom_range(1, 6);
        else if (r < 80) v = 64;
        else if (r < 90) v = 0;
        else v = $urandom_range(65, 127);
        write_reg(CFG_BUCKET_CNT, {$urandom} & 32'hFFFF_FF80 | v);
        r = $urandom_range(99);
        if (r < 50) v = $urandom_range(0, 20);
        else if (r < 75) v = $urandom_range(0, 300000);
        else v = $urandom;
        write_reg(CFG_STALE_MS, v);
    endtask

    task automatic random_poll();
        logic [63:0] bns, wns, sns, lev;
        logic op, pr, sd;
        int r;
        bns = interval_ms() * 64'd1000000;
        wns = 64'(ring_len()) * bns;
        sns = 64'(sh_stale) * 64'd1000000;
        r = $urandom_range(99);
        if (r < 60) t_ns += rand64() % (2 * bns + 1);
        else if (r < 70) t_ns = t_ns;
        else if (r < 78) t_ns += 2 * wns + rand64() % (wns + 1);
        else if (r < 85) t_ns -= (t_ns > bns) ? rand64() % bns : t_ns;
        else if (r < 90) t_ns = rand64();
        else t_ns += rand64() % (bns / 4 + 1);
        t_ns &= MASK63;
        r = $urandom_range(99);
        if (r < 88) counter += $urandom_range(0, 500);
        else if (r < 94) counter = rand64();
        r = $urandom_range(99);
        if (r < 60) begin
            lev = rand64() % (2 * sns + 2 * bns + 1);
            lev = (lev > t_ns) ? 64'd0 : t_ns - lev;
        end else if (r < 80) begin
            lev = rand64();
        end else begin
            lev = t_ns + $urandom_range(0, 1000000);
        end
        op = ($urandom_range(99) < 4) ? OP_RESET_EPOCH : OP_POLL;
        pr = $urandom_range(99) < 92;
        sd = $urandom_range(99) < 92;
        send_poll(mk(op, t_ns, pr, sd, counter, lev));
    endtask

    task automatic test_random(input int n_polls, input int idle_pct, input int stall_pct);
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        for (int i = 0; i < n_polls; i++) begin
            if (i % 80 == 0) begin
                wait_idle();
                random_config();
            end
            random_poll();
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("windowed_event_rate_monitor: mismatch");
            $finish;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        rate_rec_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                mismatches++;
            end else begin
                e = expected_q.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status);
                    mismatches++;
                end
                if (m_rate_value !== e.rate) begin
                    $error("rate_value exp %0h got %0h", e.rate, m_rate_value);
                    mismatches++;
                end
                if (m_window_total !== e.wtotal) begin
                    $error("window_total exp %0d got %0d", e.wtotal, m_window_total);
                    mismatches++;
                end
                if (m_sequence_res !== e.seq) begin
                    $error("sequence_res exp %0d got %0d", e.seq, m_sequence_res);
                    mismatches++;
                end
                if (m_mark_ns !== e.observed) begin
                    $error("mark_ns exp %0d got %0d", e.observed, m_mark_ns);
                    mismatches++;
                end
                if (m_last_source_ns !== e.src) begin
                    $error("last_source_ns exp %0d got %0d", e.src, m_last_source_ns);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        reset_shadow();
        t_ns = 64'd50_000_000;
        counter = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(560, 17, 86);
        test_random(560, 86, 17);
        test_random(560, 0, 0);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("windowed_event_rate_monitor: match");
        end else begin
            $display("windowed_event_rate_monitor: mismatch");
        end
        $finish;
    end

endmodule
